FILE: rtl/core/tpr_pkg.sv
// tpr_pkg: shared types, codes and reset values of the timed pwm ramp positioner
// used by the register block, the engine and the top level
// no dependencies

package tpr_pkg;

	localparam int RAMP_LEVELS_DEF = 20;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [15:0] RST_TIME_STOWED = 16'd0;
	localparam logic [15:0] RST_TIME_DRIVE = 16'd1500;
	localparam logic [15:0] RST_TIME_MAX = 16'd3000;
	localparam logic [15:0] RST_MAX_TRAVEL = 16'd3000;
	localparam logic [7:0] RST_MAX_PWM = 8'd255;
	localparam logic [15:0] RST_DEADBAND = 16'd50;
	localparam logic [7:0] RST_STEP = 8'd10;

	typedef enum logic [2:0] {
		REG_TIME_STOWED = 3'd0,
		REG_TIME_DRIVE = 3'd1,
		REG_TIME_MAX = 3'd2,
		REG_MAX_TRAVEL = 3'd3,
		REG_MAX_PWM = 3'd4,
		REG_DEADBAND = 3'd5,
		REG_STEP = 3'd6
	} reg_idx_t;

	typedef enum logic {
		FUNC_TICK = 1'b0,
		FUNC_CMD = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		CMD_STOWED = 2'd0,
		CMD_DRIVE = 2'd1,
		CMD_MAX = 2'd2,
		CMD_STOP = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_ACCEPTED = 2'd1,
		ST_IGNORED = 2'd2
	} cmd_status_t;

	typedef struct packed {
		logic [15:0] time_stowed_ms;
		logic [15:0] time_drive_ms;
		logic [15:0] time_max_ms;
		logic [15:0] max_travel_ms;
		logic [7:0] max_pwm;
		logic [15:0] deadband_ms;
		logic [7:0] step_ms;
	} cfg_t;

	typedef struct packed {
		logic [7:0] pwm_duty;
		logic dir_up;
		logic dir_down;
		logic busy_res;
		logic [15:0] position_ms;
		logic [1:0] mount_mode;
		logic [1:0] cmd_status;
	} result_t;

endpackage

FILE: rtl/core/tpr_if.sv
// tpr_if: valid/ready channel interfaces for items in and results out
// depends on nothing but the field widths of the positioner

interface tpr_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [1:0] command_code;

	modport source (output valid, output func, output command_code, input ready);
	modport sink (input valid, input func, input command_code, output ready);
endinterface

interface tpr_out_if;
	logic valid;
	logic ready;
	logic [7:0] pwm_duty;
	logic dir_up;
	logic dir_down;
	logic busy_res;
	logic [15:0] position_ms;
	logic [1:0] mount_mode;
	logic [1:0] cmd_status;

	modport source (output valid, output pwm_duty, output dir_up, output dir_down,
		output busy_res, output position_ms, output mount_mode, output cmd_status,
		input ready);
	modport sink (input valid, input pwm_duty, input dir_up, input dir_down,
		input busy_res, input position_ms, input mount_mode, input cmd_status,
		output ready);
endinterface

FILE: rtl/core/tpr_cfg.sv
// tpr_cfg: apb register file holding presets, limits and ramp settings
// depends on tpr_pkg

module tpr_cfg (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tpr_pkg::ADDR_W-1:0] paddr,
	input logic [tpr_pkg::DATA_W-1:0] pwdata,
	output logic [tpr_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output tpr_pkg::cfg_t cfg
);

	tpr_pkg::cfg_t cfg_q;
	tpr_pkg::reg_idx_t idx;
	logic wr_en;

	assign idx = tpr_pkg::reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_stowed_ms <= tpr_pkg::RST_TIME_STOWED;
			cfg_q.time_drive_ms <= tpr_pkg::RST_TIME_DRIVE;
			cfg_q.time_max_ms <= tpr_pkg::RST_TIME_MAX;
			cfg_q.max_travel_ms <= tpr_pkg::RST_MAX_TRAVEL;
			cfg_q.max_pwm <= tpr_pkg::RST_MAX_PWM;
			cfg_q.deadband_ms <= tpr_pkg::RST_DEADBAND;
			cfg_q.step_ms <= tpr_pkg::RST_STEP;
		end else if (wr_en) begin
			unique case (idx)
				tpr_pkg::REG_TIME_STOWED: cfg_q.time_stowed_ms <= pwdata[15:0];
				tpr_pkg::REG_TIME_DRIVE: cfg_q.time_drive_ms <= pwdata[15:0];
				tpr_pkg::REG_TIME_MAX: cfg_q.time_max_ms <= pwdata[15:0];
				tpr_pkg::REG_MAX_TRAVEL: cfg_q.max_travel_ms <= pwdata[15:0];
				tpr_pkg::REG_MAX_PWM: cfg_q.max_pwm <= pwdata[7:0];
				tpr_pkg::REG_DEADBAND: cfg_q.deadband_ms <= pwdata[15:0];
				tpr_pkg::REG_STEP: cfg_q.step_ms <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tpr_pkg::REG_TIME_STOWED: prdata = {16'd0, cfg_q.time_stowed_ms};
			tpr_pkg::REG_TIME_DRIVE: prdata = {16'd0, cfg_q.time_drive_ms};
			tpr_pkg::REG_TIME_MAX: prdata = {16'd0, cfg_q.time_max_ms};
			tpr_pkg::REG_MAX_TRAVEL: prdata = {16'd0, cfg_q.max_travel_ms};
			tpr_pkg::REG_MAX_PWM: prdata = {24'd0, cfg_q.max_pwm};
			tpr_pkg::REG_DEADBAND: prdata = {16'd0, cfg_q.deadband_ms};
			tpr_pkg::REG_STEP: prdata = {24'd0, cfg_q.step_ms};
			default: prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/tpr_engine.sv
// tpr_engine: motion state and one-item update (ramp up, hold, ramp down, position)
// depends on tpr_pkg; duty uses a reciprocal-scaled index kept next to the ramp index

module tpr_engine #(
	parameter int RAMP_LEVELS = tpr_pkg::RAMP_LEVELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic step_en,
	input logic func,
	input logic [1:0] command_code,
	input tpr_pkg::cfg_t cfg,
	output tpr_pkg::result_t res
);

	localparam int IDX_W = $clog2(RAMP_LEVELS + 1);
	localparam int NUM_W = 8 + IDX_W;
	localparam int SH_W = NUM_W + $clog2(RAMP_LEVELS);
	localparam int SC_W = SH_W + 1;
	localparam int RECIP_INT = ((1 << SH_W) + RAMP_LEVELS - 1) / RAMP_LEVELS;
	localparam logic [SC_W-1:0] RECIP = SC_W'(RECIP_INT);
	localparam logic [SC_W-1:0] SCALE_FULL = SC_W'(RAMP_LEVELS * RECIP_INT);
	localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(RAMP_LEVELS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RAMP_LEVELS - 1);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_UP = 4'b0010,
		PH_HOLD = 4'b0100,
		PH_DOWN = 4'b1000
	} phase_t;

	phase_t phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [1:0] mode_q, mode_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [SC_W-1:0] scale_q, scale_d;
	logic [15:0] tick_q, tick_d;
	logic [15:0] hold_q, hold_d;
	logic [15:0] pend_q, pend_d;
	logic up_q, up_d;
	logic [7:0] duty_q, duty_d;
	tpr_pkg::cmd_status_t status_d;

	tpr_pkg::cmd_code_t code;
	logic [15:0] target, span, hold_new, pend_new, tick_inc;
	logic [7:0] step_eff;
	logic step_hit;
	logic [SC_W-1:0] scale_up, scale_dn, mult_op;
	logic [SC_W+7:0] product;
	logic [7:0] duty_calc;
	logic busy;

	assign code = tpr_pkg::cmd_code_t'(command_code);

	always_comb begin
		unique case (code)
			tpr_pkg::CMD_STOWED: target = cfg.time_stowed_ms;
			tpr_pkg::CMD_DRIVE: target = cfg.time_drive_ms;
			tpr_pkg::CMD_MAX: target = cfg.time_max_ms;
			tpr_pkg::CMD_STOP: target = '0;
			default: target = '0;
		endcase
	end

	assign span = (target >= pos_q) ? target - pos_q : pos_q - target;
	assign hold_new = (span < cfg.max_travel_ms) ? span : cfg.max_travel_ms;
	assign pend_new = (target < cfg.max_travel_ms) ? target : cfg.max_travel_ms;

	assign tick_inc = tick_q + 16'd1;
	assign step_eff = (cfg.step_ms == 8'd0) ? 8'd1 : cfg.step_ms;
	assign step_hit = tick_inc >= {8'd0, step_eff};

	// scale tracks idx * ceil(2^SH_W / RAMP_LEVELS); duty = (max_pwm * scale) >> SH_W
	assign scale_up = scale_q + RECIP;
	assign scale_dn = scale_q - RECIP;
	assign mult_op = (phase_q == PH_UP) ? scale_up : scale_dn;
	assign product = {8'd0, mult_op} * {{SC_W{1'b0}}, cfg.max_pwm};
	assign duty_calc = product[SH_W +: 8];

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		mode_d = mode_q;
		idx_d = idx_q;
		scale_d = scale_q;
		tick_d = tick_q;
		hold_d = hold_q;
		pend_d = pend_q;
		up_d = up_q;
		duty_d = duty_q;
		status_d = tpr_pkg::ST_NONE;
		if (step_en) begin
			if (func == tpr_pkg::FUNC_CMD) begin
				if (code == tpr_pkg::CMD_STOP) begin
					phase_d = PH_IDLE;
					duty_d = '0;
					idx_d = '0;
					scale_d = '0;
					tick_d = '0;
					status_d = tpr_pkg::ST_ACCEPTED;
				end else if (phase_q != PH_IDLE) begin
					status_d = tpr_pkg::ST_IGNORED;
				end else begin
					mode_d = command_code;
					status_d = tpr_pkg::ST_ACCEPTED;
					if (span >= cfg.deadband_ms) begin
						up_d = target > pos_q;
						hold_d = hold_new;
						pend_d = pend_new;
						phase_d = PH_UP;
						idx_d = '0;
						scale_d = '0;
						tick_d = '0;
						duty_d = '0;
					end
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: ;
					PH_UP: begin
						if (step_hit) begin
							tick_d = '0;
							if (idx_q == IDX_LAST) begin
								idx_d = IDX_FULL;
								scale_d = SCALE_FULL;
								phase_d = PH_HOLD;
								// zero hold goes straight to the ramp down
								if (hold_q == '0) begin
									phase_d = PH_DOWN;
									duty_d = cfg.max_pwm;
								end
							end else begin
								idx_d = idx_q + 1'b1;
								scale_d = scale_up;
								duty_d = duty_calc;
							end
						end else begin
							tick_d = tick_inc;
						end
					end
					PH_HOLD: begin
						if (tick_inc >= hold_q) begin
							phase_d = PH_DOWN;
							idx_d = IDX_FULL;
							scale_d = SCALE_FULL;
							tick_d = '0;
							duty_d = cfg.max_pwm;
						end else begin
							tick_d = tick_inc;
						end
					end
					PH_DOWN: begin
						if (step_hit) begin
							tick_d = '0;
							if (idx_q == '0) begin
								phase_d = PH_IDLE;
								duty_d = '0;
								scale_d = '0;
								pos_d = pend_q;
							end else begin
								idx_d = idx_q - 1'b1;
								scale_d = scale_dn;
								duty_d = duty_calc;
							end
						end else begin
							tick_d = tick_inc;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q <= '0;
			mode_q <= '0;
			idx_q <= '0;
			scale_q <= '0;
			tick_q <= '0;
			hold_q <= '0;
			pend_q <= '0;
			up_q <= 1'b0;
			duty_q <= '0;
		end else begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			mode_q <= mode_d;
			idx_q <= idx_d;
			scale_q <= scale_d;
			tick_q <= tick_d;
			hold_q <= hold_d;
			pend_q <= pend_d;
			up_q <= up_d;
			duty_q <= duty_d;
		end
	end

	assign busy = phase_d != PH_IDLE;

	always_comb begin
		res.pwm_duty = duty_d;
		res.dir_up = busy && up_d;
		res.dir_down = busy && !up_d;
		res.busy_res = busy;
		res.position_ms = pos_d;
		res.mount_mode = mode_d;
		res.cmd_status = status_d;
	end

endmodule

FILE: rtl/core/timed_pwm_ramp_positioner.sv
// timed_pwm_ramp_positioner: top level with input stage, result register and apb port
// depends on tpr_pkg, tpr_if, tpr_cfg and tpr_engine
//
// usage: items arrive on the item channel (valid/ready). func 0 is a one
// millisecond tick, func 1 a command with command_code stowed, drive, max or
// stop. every accepted item gives exactly one result on the result channel,
// holding duty, direction lines, busy flag, position, mount mode and the
// command status as they stand after that item.
// pipeline: an item is registered in the input stage, is processed while it
// moves to the result register, and the result is then offered on the result
// channel. one item per cycle is sustained while the receiver takes results;
// the per-item work is a single pass through the engine with one 8-bit by
// reciprocal-scale multiply for duty.
// when the receiver stalls, the result register holds and the input stage
// takes one more item, after which item.ready drops until the result goes.
// reset (arst_n low) clears position, mode and motion to idle and loads the
// default presets; the user writes apb registers only while idle (not enforced).

module timed_pwm_ramp_positioner #(
	parameter int RAMP_LEVELS = tpr_pkg::RAMP_LEVELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [tpr_pkg::ADDR_W-1:0] paddr,
	input logic [tpr_pkg::DATA_W-1:0] pwdata,
	output logic [tpr_pkg::DATA_W-1:0] prdata,
	output logic pready,
	tpr_in_if.sink item,
	tpr_out_if.source result
);

	tpr_pkg::cfg_t cfg;
	tpr_pkg::result_t res_d;
	tpr_pkg::result_t res_s2;
	logic valid_s1, valid_s2;
	logic func_s1;
	logic [1:0] code_s1;
	logic advance, take;

	assign advance = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take = item.valid && item.ready;

	tpr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	tpr_engine #(
		.RAMP_LEVELS(RAMP_LEVELS)
	) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(advance),
		.func(func_s1),
		.command_code(code_s1),
		.cfg(cfg),
		.res(res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_s1 <= item.func;
			code_s1 <= item.command_code;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid = valid_s2;
	assign result.pwm_duty = res_s2.pwm_duty;
	assign result.dir_up = res_s2.dir_up;
	assign result.dir_down = res_s2.dir_down;
	assign result.busy_res = res_s2.busy_res;
	assign result.position_ms = res_s2.position_ms;
	assign result.mount_mode = res_s2.mount_mode;
	assign result.cmd_status = res_s2.cmd_status;

endmodule
